@@ hw/rtl/fsus_pkg.sv @@
// ----------------------------------------------------------------------------
// fsus_pkg
// Shared constants, types and helpers for the fisheye undistort sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package fsus_pkg;

  localparam int unsigned SRC_MAX_WIDTH  = 512;
  localparam int unsigned SRC_MAX_HEIGHT = 512;
  localparam int unsigned OUT_MAX_WIDTH  = 1024;
  localparam int unsigned OUT_MAX_HEIGHT = 1024;

  localparam int unsigned SCW        = $clog2(SRC_MAX_WIDTH);
  localparam int unsigned SRW        = $clog2(SRC_MAX_HEIGHT);
  localparam int unsigned IDX_W      = (SCW > SRW) ? SCW : SRW;
  localparam int unsigned BANK_AW    = SCW + SRW - 2;
  localparam int unsigned BANK_DEPTH = 2 ** BANK_AW;

  localparam int unsigned RAD_W     = 9;
  localparam int unsigned FOC_W     = 12;
  localparam int unsigned SW_W      = 10;
  localparam int unsigned OW_W      = 11;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned PIX_W     = 3 * CH_W;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // centered coordinate magnitude in half pixels, at most 1024
  localparam int unsigned MAG_W     = 11;
  localparam int unsigned MX_W      = RAD_W + MAG_W;
  localparam int unsigned NUM_W     = 2 * MX_W;
  localparam int unsigned DEN_W     = 27;
  localparam int unsigned QUO_W     = 34;
  localparam int unsigned ROOT_W    = QUO_W / 2;
  localparam int unsigned SREM_W    = ROOT_W + 2;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned NUM_SHIFT = QUO_W - 2 * FRAC_W;
  localparam int unsigned POS_W     = 19;
  localparam int unsigned LAT_PROJ  = QUO_W + ROOT_W;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 3'd0,
    REG_FOCAL  = 3'd1,
    REG_SRC_W  = 3'd2,
    REG_SRC_H  = 3'd3,
    REG_OUT_W  = 3'd4,
    REG_OUT_H  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_REQ  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [FOC_W-1:0] focal;
    logic [SW_W-1:0]  src_w;
    logic [SW_W-1:0]  src_h;
    logic [OW_W-1:0]  out_w;
    logic [OW_W-1:0]  out_h;
  } cfg_t;

  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   rgb;
  } entry_t;

  typedef struct packed {
    logic               vld;
    logic               is_load;
    logic               sx;
    logic               sy;
    logic [1:0]         wbank;
    logic [BANK_AW-1:0] waddr;
    logic [PIX_W-1:0]   rgb;
  } meta_t;

  typedef struct packed {
    logic [IDX_W-1:0]  i0;
    logic [IDX_W-1:0]  i1;
    logic [FRAC_W-1:0] fr;
  } loc_t;

  function automatic logic [SW_W-1:0] clamp_src(logic [SW_W-1:0] v, int unsigned maxv);
    logic [SW_W-1:0] r;
    if (v == '0) begin
      r = SW_W'(1);
    end else if (v > maxv) begin
      r = SW_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [OW_W-1:0] clamp_out(logic [OW_W-1:0] v, int unsigned maxv);
    logic [OW_W-1:0] r;
    if (v > maxv) begin
      r = OW_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // split a Q.8 position into clamped neighbor indices and the weight
  function automatic loc_t locate(logic signed [POS_W-1:0] p, logic [SW_W-1:0] size);
    loc_t                r;
    logic [SW_W-1:0]     a;
    logic [SW_W:0]       b;
    logic [SW_W-1:0]     lim;
    lim = size - SW_W'(1);
    a   = p[POS_W-2:FRAC_W];
    b   = {1'b0, a} + (SW_W+1)'(1);
    if (p[POS_W-1]) begin
      r = '0;
    end else begin
      r.fr = p[FRAC_W-1:0];
      r.i0 = (a > lim) ? lim[IDX_W-1:0] : a[IDX_W-1:0];
      r.i1 = (b > {1'b0, lim}) ? lim[IDX_W-1:0] : b[IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fsus_front.sv @@
// ----------------------------------------------------------------------------
// fsus_front
// Input side: accepts requests, drops out-of-view reads and loads outside the source memory.
// ----------------------------------------------------------------------------
`default_nettype none

module fsus_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [fsus_pkg::COORD_W-1:0] col_i,
  input  logic [fsus_pkg::COORD_W-1:0] row_i,
  input  logic [fsus_pkg::PIX_W-1:0]   rgb_i,
  input  fsus_pkg::cfg_t               cfg_i,
  input  logic                         full_i,
  output logic                         push_o,
  output fsus_pkg::entry_t             entry_o
);
  import fsus_pkg::*;

  logic [OW_W-1:0] ow, oh;
  logic            keep;

  always_comb begin
    ow = clamp_out(cfg_i.out_w, OUT_MAX_WIDTH);
    oh = clamp_out(cfg_i.out_h, OUT_MAX_HEIGHT);
    if (mode_e'(mode_i) == MODE_LOAD) begin
      keep = ({1'b0, col_i} < (COORD_W+1)'(SRC_MAX_WIDTH)) &&
             ({1'b0, row_i} < (COORD_W+1)'(SRC_MAX_HEIGHT));
    end else begin
      keep = ({1'b0, col_i} < ow) && ({1'b0, row_i} < oh);
    end
    in_stall_o      = full_i;
    push_o          = in_valid_i && !full_i && keep;
    entry_o.is_load = (mode_e'(mode_i) == MODE_LOAD);
    entry_o.col     = col_i;
    entry_o.row     = row_i;
    entry_o.rgb     = rgb_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/fsus_fifo.sv @@
// ----------------------------------------------------------------------------
// fsus_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fsus_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fsus_pkg::entry_t din_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output fsus_pkg::entry_t dout_o
);
  import fsus_pkg::*;

  entry_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [FIFO_AW:0]     cnt_q, cnt_d;

  always_comb begin
    full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
    empty_o = (cnt_q == '0);
    dout_o  = mem_q[rptr_q];
    cnt_d   = cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fsus_proj.sv @@
// ----------------------------------------------------------------------------
// fsus_proj
// Pipelined floor(256n / sqrt(s)): restoring divider for (n^2 << 16)/s, one
// quotient bit per stage, then a digit-by-digit square root, two bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fsus_proj (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [fsus_pkg::NUM_W-1:0]  num_i,
  input  logic [fsus_pkg::DEN_W-1:0]  den_i,
  input  logic                        zero_i,
  output logic [fsus_pkg::ROOT_W-1:0] q_o
);
  import fsus_pkg::*;

  logic [DEN_W-1:0]  drem_q [QUO_W];
  logic [QUO_W-1:0]  dlow_q [QUO_W];
  logic [QUO_W-1:0]  dquo_q [QUO_W];
  logic [DEN_W-1:0]  dden_q [QUO_W];
  logic              dzero_q [QUO_W];

  logic [SREM_W-1:0] srem_q [ROOT_W];
  logic [ROOT_W-1:0] sroot_q [ROOT_W];
  logic [QUO_W-1:0]  sopd_q [ROOT_W];

  genvar k;
  for (k = 0; k < QUO_W; k++) begin : g_div
    logic [DEN_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] low_in, quo_in;
    logic             zero_in;
    logic [DEN_W:0]   t;
    logic             ge;

    if (k == 0) begin : g_first
      // numerator is num << 16; its top bits start the remainder
      assign rem_in  = DEN_W'(num_i[NUM_W-1:NUM_SHIFT]);
      assign low_in  = {num_i[NUM_SHIFT-1:0], {(QUO_W-NUM_SHIFT){1'b0}}};
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign zero_in = zero_i;
    end else begin : g_next
      assign rem_in  = drem_q[k-1];
      assign low_in  = dlow_q[k-1];
      assign quo_in  = dquo_q[k-1];
      assign den_in  = dden_q[k-1];
      assign zero_in = dzero_q[k-1];
    end

    assign t  = {rem_in, low_in[QUO_W-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        drem_q[k]  <= ge ? DEN_W'(t - {1'b0, den_in}) : t[DEN_W-1:0];
        dlow_q[k]  <= {low_in[QUO_W-2:0], 1'b0};
        dquo_q[k]  <= {quo_in[QUO_W-2:0], ge};
        dden_q[k]  <= den_in;
        dzero_q[k] <= zero_in;
      end
    end
  end

  genvar j;
  for (j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [SREM_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [QUO_W-1:0]  opd_in;
    logic [SREM_W+1:0] t, trial;
    logic              ge;

    if (j == 0) begin : g_first
      // a degenerate mapping yields zero
      assign opd_in  = dzero_q[QUO_W-1] ? '0 : dquo_q[QUO_W-1];
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign opd_in  = sopd_q[j-1];
      assign rem_in  = srem_q[j-1];
      assign root_in = sroot_q[j-1];
    end

    assign t     = {rem_in, opd_in[QUO_W-1:QUO_W-2]};
    assign trial = (SREM_W+2)'({root_in, 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        srem_q[j]  <= ge ? SREM_W'(t - trial) : SREM_W'(t);
        sroot_q[j] <= {root_in[ROOT_W-2:0], ge};
        sopd_q[j]  <= {opd_in[QUO_W-3:0], 2'b00};
      end
    end
  end

  assign q_o = sroot_q[ROOT_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/fsus_back.sv @@
// ----------------------------------------------------------------------------
// fsus_back
// Execution pipeline: centering, spherical mapping, source memory banks and
// bilinear blend. Loads travel the same pipe and write at the memory stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fsus_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fsus_pkg::cfg_t             cfg_i,
  input  logic                       empty_i,
  input  fsus_pkg::entry_t           head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fsus_pkg::CH_W-1:0]  out_red_o,
  output logic [fsus_pkg::CH_W-1:0]  out_green_o,
  output logic [fsus_pkg::CH_W-1:0]  out_blue_o
);
  import fsus_pkg::*;

  logic            adv;
  logic [OW_W-1:0] ow, oh;
  logic [SW_W-1:0] sw, sh;

  // stage 1: centered coordinates
  logic signed [12:0] x2, y2;
  logic [12:0]        xa, ya;
  meta_t              meta1_d, meta1_q;
  logic [MAG_W-1:0]   ax_q, ay_q;

  // stage 2: products
  meta_t              meta2_q;
  logic [MX_W-1:0]    mx_q, my_q;
  logic [2*MAG_W-1:0] sqx_q, sqy_q;
  logic [2*FOC_W-1:0] sqf_q;

  // stage 3: squared numerators and the common denominator
  meta_t              meta3_q;
  logic [NUM_W-1:0]   numx_q, numy_q;
  logic [DEN_W-1:0]   den_d, den_q;
  logic               zero_q;

  meta_t              meta_ln_q [LAT_PROJ];
  logic [ROOT_W-1:0]  qx, qy;

  // position stage
  logic signed [POS_W-1:0] bu, bv, qxe, qye, pu, pv;
  meta_t              metap_q;
  loc_t               lu_q, lv_q;

  // memory stage
  meta_t              metam_q;
  logic [PIX_W-1:0]   rd_q [4];
  logic               u0p_q, u1p_q, v0p_q, v1p_q;
  logic [FRAC_W-1:0]  fu_q, fvm_q;

  // blend stages
  meta_t              metab_q;
  logic [PIX_W-1:0]   p00, p01, p10, p11;
  logic [FRAC_W:0]    wu0, wv0;
  logic [16:0]        top_d [3], bot_d [3];
  logic [16:0]        top_q [3], bot_q [3];
  logic [FRAC_W-1:0]  fvb_q;
  logic [25:0]        acc [3];
  logic [CH_W-1:0]    res [3];

  logic               out_vld_q;
  logic [CH_W-1:0]    out_q [3];

  always_comb begin
    adv   = !out_vld_q || !out_stall_i;
    pop_o = adv && !empty_i;
    ow    = clamp_out(cfg_i.out_w, OUT_MAX_WIDTH);
    oh    = clamp_out(cfg_i.out_h, OUT_MAX_HEIGHT);
    sw    = clamp_src(cfg_i.src_w, SRC_MAX_WIDTH);
    sh    = clamp_src(cfg_i.src_h, SRC_MAX_HEIGHT);

    x2 = $signed({2'b00, head_i.col, 1'b0}) - $signed({2'b00, ow});
    y2 = $signed({2'b00, oh}) - $signed({2'b00, head_i.row, 1'b0});
    xa = x2[12] ? (~x2 + 13'd1) : x2;
    ya = y2[12] ? (~y2 + 13'd1) : y2;

    meta1_d.vld     = pop_o;
    meta1_d.is_load = head_i.is_load;
    meta1_d.sx      = x2[12];
    meta1_d.sy      = y2[12];
    meta1_d.wbank   = {head_i.row[0], head_i.col[0]};
    meta1_d.waddr   = {head_i.row[SRW-1:1], head_i.col[SCW-1:1]};
    meta1_d.rgb     = head_i.rgb;

    den_d = DEN_W'(sqx_q) + DEN_W'(sqy_q) + DEN_W'({sqf_q, 2'b00});

    bu  = $signed(POS_W'({sw[SW_W-1:1], {FRAC_W{1'b0}}}));
    bv  = $signed(POS_W'({sh[SW_W-1:1], {FRAC_W{1'b0}}}));
    qxe = $signed(POS_W'(qx));
    qye = $signed(POS_W'(qy));
    pu  = meta_ln_q[LAT_PROJ-1].sx ? (bu - qxe) : (bu + qxe);
    pv  = meta_ln_q[LAT_PROJ-1].sy ? (bv + qye) : (bv - qye);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
      meta3_q <= '0;
      metap_q <= '0;
      metam_q <= '0;
      metab_q <= '0;
      for (int i = 0; i < LAT_PROJ; i++) begin
        meta_ln_q[i] <= '0;
      end
    end else if (adv) begin
      meta1_q      <= meta1_d;
      meta2_q      <= meta1_q;
      meta3_q      <= meta2_q;
      meta_ln_q[0] <= meta3_q;
      for (int i = 1; i < LAT_PROJ; i++) begin
        meta_ln_q[i] <= meta_ln_q[i-1];
      end
      metap_q <= meta_ln_q[LAT_PROJ-1];
      metam_q <= metap_q;
      metab_q <= metam_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q   <= xa[MAG_W-1:0];
      ay_q   <= ya[MAG_W-1:0];
      mx_q   <= MX_W'(cfg_i.radius) * MX_W'(ax_q);
      my_q   <= MX_W'(cfg_i.radius) * MX_W'(ay_q);
      sqx_q  <= (2*MAG_W)'(ax_q) * (2*MAG_W)'(ax_q);
      sqy_q  <= (2*MAG_W)'(ay_q) * (2*MAG_W)'(ay_q);
      sqf_q  <= (2*FOC_W)'(cfg_i.focal) * (2*FOC_W)'(cfg_i.focal);
      numx_q <= NUM_W'(mx_q) * NUM_W'(mx_q);
      numy_q <= NUM_W'(my_q) * NUM_W'(my_q);
      den_q  <= den_d;
      zero_q <= (den_d == '0);
      lu_q   <= locate(pu, sw);
      lv_q   <= locate(pv, sh);
      u0p_q  <= lu_q.i0[0];
      u1p_q  <= lu_q.i1[0];
      v0p_q  <= lv_q.i0[0];
      v1p_q  <= lv_q.i1[0];
      fu_q   <= lu_q.fr;
      fvm_q  <= lv_q.fr;
      fvb_q  <= fvm_q;
      top_q  <= top_d;
      bot_q  <= bot_d;
    end
  end

  fsus_proj u_proj_x (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .num_i  (numx_q),
    .den_i  (den_q),
    .zero_i (zero_q),
    .q_o    (qx)
  );

  fsus_proj u_proj_y (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .num_i  (numy_q),
    .den_i  (den_q),
    .zero_i (zero_q),
    .q_o    (qy)
  );

  // four banks by row and column parity: each distinct neighbor lands in its own bank
  genvar b;
  for (b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0]   mem [BANK_DEPTH];
    logic [IDX_W-1:0]   rrow, rcol;
    logic [BANK_AW-1:0] ra;
    logic               we;

    always_comb begin
      rrow = (lv_q.i0[0] == 1'(b >> 1)) ? lv_q.i0 : lv_q.i1;
      rcol = (lu_q.i0[0] == 1'(b & 1))  ? lu_q.i0 : lu_q.i1;
      ra   = {rrow[SRW-1:1], rcol[SCW-1:1]};
      we   = metap_q.vld && metap_q.is_load && (metap_q.wbank == 2'(b));
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (we) begin
          mem[metap_q.waddr] <= metap_q.rgb;
        end
        rd_q[b] <= mem[ra];
      end
    end
  end

  always_comb begin
    p00 = rd_q[{v0p_q, u0p_q}];
    p01 = rd_q[{v0p_q, u1p_q}];
    p10 = rd_q[{v1p_q, u0p_q}];
    p11 = rd_q[{v1p_q, u1p_q}];
    wu0 = 9'd256 - {1'b0, fu_q};
    wv0 = 9'd256 - {1'b0, fvb_q};
  end

  genvar c;
  for (c = 0; c < 3; c++) begin : g_chan
    localparam int unsigned SH = (2 - c) * CH_W;
    always_comb begin
      top_d[c] = 17'(p00[SH +: CH_W]) * 17'(wu0) + 17'(p01[SH +: CH_W]) * 17'(fu_q);
      bot_d[c] = 17'(p10[SH +: CH_W]) * 17'(wu0) + 17'(p11[SH +: CH_W]) * 17'(fu_q);
      acc[c]   = 26'(top_q[c]) * 26'(wv0) + 26'(bot_q[c]) * 26'(fvb_q);
      res[c]   = acc[c][23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= metab_q.vld && !metab_q.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

endmodule

`default_nettype wire

@@ hw/rtl/fisheye_sphere_undistort_sampler_core.sv @@
// ----------------------------------------------------------------------------
// fisheye_sphere_undistort_sampler_core
// Fisheye to perspective correction with bilinear sampling.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid_i / in_stall_o) carries two kinds of
// request. mode 0 writes a source pixel into the source image memory; mode 1
// asks for one corrected pixel at (col,row) of the view plane, returned on
// the output channel (out_valid_o / out_stall_i). Loads and out-of-view
// requests produce no output. Configuration is written through cfg_we_i /
// cfg_idx_i / cfg_wdata_i; the user must write it only while no request is
// in flight, which the block does not enforce. Throughput: one request per
// cycle while the output is not stalled, loads and reads freely interleaved.
// The 34-stage divider and 17-stage square root of the mapping dominate the pipe.
// Reset clears the pipeline and restores configuration defaults; the source
// memory is undefined until loaded. When the receiver stalls, the whole pipe
// holds, the short input queue fills and then in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module fisheye_sphere_undistort_sampler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsus_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fsus_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [fsus_pkg::COORD_W-1:0]   col_i,
  input  logic [fsus_pkg::COORD_W-1:0]   row_i,
  input  logic [fsus_pkg::CH_W-1:0]      in_red_i,
  input  logic [fsus_pkg::CH_W-1:0]      in_green_i,
  input  logic [fsus_pkg::CH_W-1:0]      in_blue_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fsus_pkg::CH_W-1:0]      out_red_o,
  output logic [fsus_pkg::CH_W-1:0]      out_green_o,
  output logic [fsus_pkg::CH_W-1:0]      out_blue_o
);
  import fsus_pkg::*;

  cfg_t   cfg_q;
  logic   push, pop, full, empty;
  entry_t entry, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius <= RAD_W'(256);
      cfg_q.focal  <= FOC_W'(256);
      cfg_q.src_w  <= SW_W'(512);
      cfg_q.src_h  <= SW_W'(512);
      cfg_q.out_w  <= OW_W'(640);
      cfg_q.out_h  <= OW_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RADIUS: cfg_q.radius <= cfg_wdata_i[RAD_W-1:0];
        REG_FOCAL:  cfg_q.focal  <= cfg_wdata_i[FOC_W-1:0];
        REG_SRC_W:  cfg_q.src_w  <= cfg_wdata_i[SW_W-1:0];
        REG_SRC_H:  cfg_q.src_h  <= cfg_wdata_i[SW_W-1:0];
        REG_OUT_W:  cfg_q.out_w  <= cfg_wdata_i[OW_W-1:0];
        REG_OUT_H:  cfg_q.out_h  <= cfg_wdata_i[OW_W-1:0];
        default: ;
      endcase
    end
  end

  fsus_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .rgb_i      ({in_red_i, in_green_i, in_blue_i}),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  fsus_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .dout_o  (head)
  );

  fsus_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/fsus_checker.sv @@
// ----------------------------------------------------------------------------
// fsus_checker
// Port-level checks on the sampler core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fsus_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [fsus_pkg::CH_W-1:0]    out_red_o,
  input logic [fsus_pkg::CH_W-1:0]    out_green_o,
  input logic [fsus_pkg::CH_W-1:0]    out_blue_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o))
    else $error("stalled result changed");

  // the pipeline is deep: no result right after reset
  a_latency: assert property (@(posedge clk_i)
    out_valid_o |-> $past(rst_ni, 3))
    else $error("result too soon after reset");

  a_rst_ready: assert property (@(posedge clk_i)
    !rst_ni |-> !in_stall_o)
    else $error("input stalled during reset");

endmodule

bind fisheye_sphere_undistort_sampler_core fsus_checker u_fsus_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_red_o   (out_red_o),
  .out_green_o (out_green_o),
  .out_blue_o  (out_blue_o)
);

`default_nettype wire

@@ tb/fisheye_sphere_undistort_sampler_core_test.sv @@
// ----------------------------------------------------------------------------
// fisheye_sphere_undistort_sampler_core_test
// Self-checking bench for the fisheye undistort sampler: loads source pixels,
// requests corrected pixels under many view and lens settings, and compares
// every returned pixel with a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module fisheye_sphere_undistort_sampler_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fsus_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int STUCK_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;

  typedef logic [PIX_W-1:0] pixel_t;

  class undistort_scoreboard;
    int unsigned radius, focal, src_w, src_h, out_w, out_h;
    pixel_t      image [int];
    pixel_t      pending_px [$];
    int          errors;
    int          checked;

    function new();
      radius = 256; focal = 256; src_w = 512; src_h = 512; out_w = 640; out_h = 480;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, int unsigned v);
      case (idx)
        REG_RADIUS: radius = v & 'h1FF;
        REG_FOCAL:  focal  = v & 'hFFF;
        REG_SRC_W:  src_w  = v & 'h3FF;
        REG_SRC_H:  src_h  = v & 'h3FF;
        REG_OUT_W:  out_w  = v & 'h7FF;
        REG_OUT_H:  out_h  = v & 'h7FF;
        default: ;
      endcase
    endfunction

    function int unsigned view_w();
      return (out_w > OUT_MAX_WIDTH) ? OUT_MAX_WIDTH : out_w;
    endfunction

    function int unsigned view_h();
      return (out_h > OUT_MAX_HEIGHT) ? OUT_MAX_HEIGHT : out_h;
    endfunction

    function int unsigned fit_src(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function longint unsigned root(longint unsigned a);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (a >= res + bitv) begin
          a   = a - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Q.8 disc offset, truncated toward zero
    function longint disc_offset(longint c, longint unsigned s);
      longint unsigned mag, n, q;
      mag = (c < 0) ? -c : c;
      n   = radius * mag * 256;
      if (s == 0) return 0;
      q = root((n * n) / s);
      return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void split_axis(longint p, int unsigned size, output int i0, output int i1,
                             output int fr);
      longint a;
      if (p < 0) begin
        i0 = 0; i1 = 0; fr = 0;
      end else begin
        a  = p >>> 8;
        fr = int'(p & 255);
        i0 = (a > size - 1) ? int'(size - 1) : int'(a);
        i1 = (a + 1 > size - 1) ? int'(size - 1) : int'(a + 1);
      end
    endfunction

    // neighbor addresses of a request; returns 0 when outside the view
    function bit map_pixel(int col, int row, output int addr[4], output int fu,
                           output int fv);
      int unsigned ow, oh, sw, sh;
      longint x2, y2, pu, pv;
      longint unsigned s;
      int u0, u1, v0, v1;
      ow = view_w();
      oh = view_h();
      if (col >= ow || row >= oh) return 0;
      sw = fit_src(src_w, SRC_MAX_WIDTH);
      sh = fit_src(src_h, SRC_MAX_HEIGHT);
      x2 = 2 * longint'(col) - longint'(ow);
      y2 = longint'(oh) - 2 * longint'(row);
      s  = x2 * x2 + y2 * y2 + 4 * longint'(focal) * longint'(focal);
      pu = longint'((sw / 2) * 256) + disc_offset(x2, s);
      pv = longint'((sh / 2) * 256) - disc_offset(y2, s);
      split_axis(pu, sw, u0, u1, fu);
      split_axis(pv, sh, v0, v1, fv);
      addr[0] = v0 * SRC_MAX_WIDTH + u0;
      addr[1] = v0 * SRC_MAX_WIDTH + u1;
      addr[2] = v1 * SRC_MAX_WIDTH + u0;
      addr[3] = v1 * SRC_MAX_WIDTH + u1;
      return 1;
    endfunction

    function void note_request(bit mode, int col, int row, pixel_t rgb);
      int addr[4];
      int fu, fv, k;
      longint unsigned top, bot;
      pixel_t p[4];
      pixel_t res;
      if (mode == MODE_LOAD) begin
        if (col < SRC_MAX_WIDTH && row < SRC_MAX_HEIGHT)
          image[row * SRC_MAX_WIDTH + col] = rgb;
        return;
      end
      if (!map_pixel(col, row, addr, fu, fv)) return;
      for (k = 0; k < 4; k++) p[k] = image.exists(addr[k]) ? image[addr[k]] : '0;
      for (k = 0; k < 3; k++) begin
        top = p[0][16-8*k +: 8] * (256 - fu) + p[1][16-8*k +: 8] * fu;
        bot = p[2][16-8*k +: 8] * (256 - fu) + p[3][16-8*k +: 8] * fu;
        res[16-8*k +: 8] = 8'((top * (256 - fv) + bot * fv) >> 16);
      end
      pending_px.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(pixel_t got);
      pixel_t want;
      if (pending_px.size() == 0) begin
        report($sformatf("unexpected pixel %06h", got));
        return;
      end
      want = pending_px.pop_front();
      checked++;
      if (got[23:16] !== want[23:16])
        report($sformatf("red %02h, want %02h", got[23:16], want[23:16]));
      if (got[15:8] !== want[15:8])
        report($sformatf("green %02h, want %02h", got[15:8], want[15:8]));
      if (got[7:0] !== want[7:0])
        report($sformatf("blue %02h, want %02h", got[7:0], want[7:0]));
    endtask
  endclass

  logic                 clk_i, rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i, in_stall_o, mode_i;
  logic [COORD_W-1:0]   col_i, row_i;
  logic [CH_W-1:0]      in_red_i, in_green_i, in_blue_i;
  logic                 out_valid_o, out_stall_i;
  logic [CH_W-1:0]      out_red_o, out_green_o, out_blue_o;

  undistort_scoreboard sb = new();
  bit quiet, hold_req;
  int n_req, n_load, n_phase, stuck;

  fisheye_sphere_undistort_sampler_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .mode_i, .col_i, .row_i,
    .in_red_i, .in_green_i, .in_blue_i,
    .out_valid_o, .out_stall_i, .out_red_o, .out_green_o, .out_blue_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({out_red_o, out_green_o, out_blue_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", STUCK_LIMIT);
      $display("[fisheye_sphere_undistort_sampler_core] ERROR");
      $finish;
    end
  end

  // receiver side: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task send(bit mode, int col, int row, pixel_t rgb);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    col_i      <= COORD_W'(col);
    row_i      <= COORD_W'(row);
    {in_red_i, in_green_i, in_blue_i} <= rgb;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(mode, col, row, rgb);
    if (mode == MODE_LOAD) n_load++;
    else n_req++;
    @(negedge clk_i);
  endtask

  // load any neighbor not yet written, then issue the request
  task request_pixel(int col, int row);
    int addr[4];
    int fu, fv, k;
    if (sb.map_pixel(col, row, addr, fu, fv)) begin
      for (k = 0; k < 4; k++)
        if (!sb.image.exists(addr[k]))
          send(MODE_LOAD, addr[k] % SRC_MAX_WIDTH, addr[k] / SRC_MAX_WIDTH,
               pixel_t'($urandom));
    end
    send(MODE_REQ, col, row, pixel_t'($urandom));
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending_px.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task cfg_write(cfg_reg_e idx, int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(v);
    @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task setup(int unsigned r, int unsigned f, int unsigned sw, int unsigned sh,
             int unsigned ow, int unsigned oh);
    drain();
    cfg_write(REG_RADIUS, r);
    cfg_write(REG_FOCAL, f);
    cfg_write(REG_SRC_W, sw);
    cfg_write(REG_SRC_H, sh);
    cfg_write(REG_OUT_W, ow);
    cfg_write(REG_OUT_H, oh);
    n_phase++;
  endtask

  task random_items(int n);
    int k, ow, oh, sw, sh;
    ow = sb.view_w();
    oh = sb.view_h();
    sw = sb.fit_src(sb.src_w, SRC_MAX_WIDTH);
    sh = sb.fit_src(sb.src_h, SRC_MAX_HEIGHT);
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        if (ow == 0 || oh == 0 || $urandom_range(0, 9) == 0)
          request_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          request_pixel($urandom_range(0, ow - 1), $urandom_range(0, oh - 1));
      end else if (k < 90) begin
        send(MODE_LOAD, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
             pixel_t'($urandom));
      end else begin
        send(MODE_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023),
             pixel_t'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    mode_i      = 1'b0;
    col_i       = '0;
    row_i       = '0;
    in_red_i    = '0;
    in_green_i  = '0;
    in_blue_i   = '0;
    quiet = 0; hold_req = 0; stuck = 0; n_req = 0; n_load = 0; n_phase = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults from reset: center, corners, out of view, ignored loads
    send(MODE_LOAD, 1023, 1023, 24'hFFFFFF);
    send(MODE_LOAD, 512, 0, 24'h000000);
    send(MODE_LOAD, 0, 512, 24'hFFFFFF);
    request_pixel(320, 240);
    request_pixel(0, 0);
    request_pixel(639, 479);
    request_pixel(639, 0);
    request_pixel(0, 479);
    request_pixel(640, 0);
    request_pixel(0, 480);
    request_pixel(1023, 1023);
    send(MODE_LOAD, 256, 256, 24'hFFFFFF);
    send(MODE_LOAD, 256, 256, 24'h000000);
    request_pixel(320, 240);

    // small sizes, the largest, oversized with a degenerate center, then all zeros
    setup(1, 1, 2, 2, 1, 1);
    request_pixel(0, 0);
    request_pixel(1, 0);
    setup(511, 4095, 512, 512, 1024, 1024);
    request_pixel(0, 0);
    request_pixel(1023, 1023);
    request_pixel(512, 512);
    setup(300, 0, 1023, 1023, 2047, 2047);
    request_pixel(512, 512);
    request_pixel(1023, 0);
    setup(0, 0, 0, 0, 0, 0);
    request_pixel(0, 0);
    send(MODE_LOAD, 0, 0, pixel_t'($urandom));

    // fill up the pipe while the receiver holds off
    setup(256, 256, 64, 48, 96, 64);
    hold_req = 1;
    random_items(50);
    random_items(30);

    repeat (5) begin
      setup($urandom_range(0, 511), $urandom_range(0, 4095), $urandom_range(0, 1023),
            $urandom_range(0, 1023), $urandom_range(0, 2047), $urandom_range(0, 2047));
      random_items(25);
      setup($urandom_range(1, 300), $urandom_range(1, 600), $urandom_range(2, 64),
            $urandom_range(2, 64), $urandom_range(1, 128), $urandom_range(1, 128));
      random_items(30);
    end

    setup(511, 4095, 512, 512, 1024, 1024);
    quiet = 1;
    random_items(30);
    drain();

    $display("covered %0d phases: %0d loads, %0d requests, %0d pixels checked",
             n_phase, n_load, n_req, sb.checked);
    if (sb.errors == 0) begin
      $display("[fisheye_sphere_undistort_sampler_core] OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[fisheye_sphere_undistort_sampler_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
